// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file nse_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define NSE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked while reset is high.
`define NSE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/nse_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package nse_pkg;

  localparam int LINE_MAX   = 128;
  localparam int MAX_FIELDS = 32;
  localparam int LANES      = 7;
  localparam int FRAC_MAX   = LANES - 1;
  localparam int HDR_LEN    = 6;

  localparam int LC_W   = 8;
  localparam int FPOS_W = 5;
  localparam int MAG_W  = 48;
  localparam int SUM_W  = MAG_W + 4;
  localparam int FC_W   = 3;

  localparam logic [LC_W-1:0]   LINE_LIMIT = LC_W'(LINE_MAX);
  localparam logic [FPOS_W-1:0] FPOS_LAST  = FPOS_W'(MAX_FIELDS - 1);
  localparam logic [MAG_W-1:0]  MAG_LIMIT  = 48'h8000_0000_0000;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;

  localparam logic [47:0] HDR_RMC = 48'h2447_5052_4D43;
  localparam logic [47:0] HDR_VTG = 48'h2447_5056_5447;
  localparam logic [47:0] HDR_ZDA = 48'h2447_505A_4441;
  localparam logic [47:0] HDR_GGA = 48'h2447_5047_4741;
  localparam logic [47:0] HDR_GLL = 48'h2447_5047_4C4C;
  localparam logic [47:0] HDR_GSA = 48'h2447_5047_5341;
  localparam logic [47:0] HDR_GSV = 48'h2447_5047_5356;

  typedef enum logic [2:0] {
    KIND_RMC = 3'd0,
    KIND_VTG = 3'd1,
    KIND_ZDA = 3'd2,
    KIND_GGA = 3'd3,
    KIND_GLL = 3'd4,
    KIND_GSA = 3'd5,
    KIND_GSV = 3'd6
  } kind_t;

  typedef struct packed {
    logic  hit;
    kind_t kind;
  } hdr_match_t;

  typedef struct packed {
    logic clear_field;
    logic feed;
    logic emit;
    logic last;
  } line_ctrl_t;

  typedef struct packed {
    logic [MAG_W-1:0] lane;
    logic             lane_sat;
    logic             overflow;
    logic             negative;
    logic [FC_W-1:0]  fc;
    logic             started;
    logic [7:0]       first;
    logic             star;
    logic             hex_any;
    logic [7:0]       hex;
  } field_view_t;

  typedef struct packed {
    kind_t             kind;
    logic [FPOS_W-1:0] fpos;
    logic [MAG_W-1:0]  value;
    logic              sat;
    logic [7:0]        first;
    logic              has_ck;
    logic [7:0]        ck;
    logic              last;
  } result_t;

  function automatic hdr_match_t hdr_lookup(input logic [47:0] hdr);
    hdr_match_t m;
    m.hit  = 1'b1;
    m.kind = KIND_RMC;
    case (hdr)
      HDR_RMC: m.kind = KIND_RMC;
      HDR_VTG: m.kind = KIND_VTG;
      HDR_ZDA: m.kind = KIND_ZDA;
      HDR_GGA: m.kind = KIND_GGA;
      HDR_GLL: m.kind = KIND_GLL;
      HDR_GSA: m.kind = KIND_GSA;
      HDR_GSV: m.kind = KIND_GSV;
      default: m.hit = 1'b0;
    endcase
    return m;
  endfunction

  function automatic logic [19:0] pow10(input logic [2:0] k);
    logic [19:0] p;
    case (k)
      3'd0:    p = 20'd1;
      3'd1:    p = 20'd10;
      3'd2:    p = 20'd100;
      3'd3:    p = 20'd1000;
      3'd4:    p = 20'd10000;
      3'd5:    p = 20'd100000;
      3'd6:    p = 20'd1000000;
      default: p = 20'd0;
    endcase
    return p;
  endfunction

  // The saturated magnitude divided by ten to the power k.
  function automatic logic [MAG_W-1:0] cap_div(input logic [2:0] k);
    logic [MAG_W-1:0] v;
    case (k)
      3'd1:    v = 48'd14073748835532;
      3'd2:    v = 48'd1407374883553;
      3'd3:    v = 48'd140737488355;
      3'd4:    v = 48'd14073748835;
      3'd5:    v = 48'd1407374883;
      3'd6:    v = 48'd140737488;
      default: v = MAG_LIMIT;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== sv/nse_line.sv =====
`timescale 1ns / 1ps
`default_nettype none
module nse_line (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      proc,
  input  wire logic [7:0]                rx_char,
  output nse_pkg::line_ctrl_t            ctrl,
  output nse_pkg::kind_t                 kind,
  output logic [nse_pkg::FPOS_W-1:0]     fpos
);
  import nse_pkg::*;

  logic [LC_W-1:0]   line_count, line_count_next;
  logic [47:0]       header, header_next;
  logic              accepted, accepted_next;
  kind_t             kind_next;
  logic [FPOS_W-1:0] fpos_next;
  hdr_match_t        match;

  always_comb begin
    line_count_next = line_count;
    header_next     = header;
    accepted_next   = accepted;
    kind_next       = kind;
    fpos_next       = fpos;
    ctrl            = '0;
    match           = hdr_lookup({header[39:0], rx_char});
    if (proc) begin
      if (rx_char == CH_LF || line_count >= LINE_LIMIT) begin
        ctrl.emit        = accepted && (fpos != '0);
        ctrl.last        = 1'b1;
        ctrl.clear_field = 1'b1;
        line_count_next  = '0;
        header_next      = '0;
        accepted_next    = 1'b0;
        kind_next        = KIND_RMC;
        fpos_next        = '0;
      end else begin
        line_count_next = line_count + 1'b1;
        if (line_count < LC_W'(HDR_LEN)) begin
          header_next = {header[39:0], rx_char};
          if (line_count == LC_W'(HDR_LEN - 1) && match.hit) begin
            accepted_next = 1'b1;
            kind_next     = match.kind;
          end
        end else if (accepted) begin
          if (rx_char == CH_COMMA) begin
            if (fpos == '0) begin
              fpos_next        = FPOS_W'(1);
              ctrl.clear_field = 1'b1;
            end else if (fpos >= FPOS_LAST) begin
              ctrl.emit     = 1'b1;
              ctrl.last     = 1'b1;
              accepted_next = 1'b0;
            end else begin
              ctrl.emit        = 1'b1;
              ctrl.clear_field = 1'b1;
              fpos_next        = fpos + 1'b1;
            end
          end else if (fpos != '0) begin
            ctrl.feed = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= '0;
      header     <= '0;
      accepted   <= 1'b0;
      kind       <= KIND_RMC;
      fpos       <= '0;
    end else begin
      line_count <= line_count_next;
      header     <= header_next;
      accepted   <= accepted_next;
      kind       <= kind_next;
      fpos       <= fpos_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/nse_field.sv =====
`timescale 1ns / 1ps
`default_nettype none
module nse_field (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire nse_pkg::line_ctrl_t       ctrl,
  input  wire logic [7:0]                rx_char,
  input  wire logic [nse_pkg::FC_W-1:0]  frac_set,
  output nse_pkg::field_view_t           view
);
  import nse_pkg::*;

  // Lane t holds the magnitude scaled to t fractional digits, saturated.
  logic [MAG_W-1:0] lane [LANES];
  logic [MAG_W-1:0] lane_next [LANES];
  logic [LANES-1:0] lane_sat, lane_sat_next;

  logic [MAG_W-1:0] mag, mag_next;
  logic             overflow, overflow_next;
  logic             negative, negative_next;
  logic             point, point_next;
  logic [FC_W-1:0]  fc, fc_next;
  logic             started, started_next;
  logic [7:0]       first, first_next;
  logic             begun, begun_next;
  logic             done, done_next;
  logic             star, star_next;
  logic             hex_any, hex_any_next;
  logic             hex_done, hex_done_next;
  logic [7:0]       hex, hex_next;

  logic       is_digit, is_ws, int_step, frac_step;
  logic [3:0] digit, hex_digit;
  logic       hex_ok;

  assign is_digit  = (rx_char >= CH_0) && (rx_char <= CH_9);
  assign digit     = 4'(rx_char - CH_0);
  assign is_ws     = (rx_char == CH_SPACE) || ((rx_char >= CH_TAB) && (rx_char <= CH_CR));
  assign int_step  = ctrl.feed && !done && is_digit && !point;
  assign frac_step = ctrl.feed && !done && is_digit && point && (fc < frac_set);

  always_comb begin
    hex_ok    = 1'b1;
    hex_digit = '0;
    if (is_digit) begin
      hex_digit = digit;
    end else if (rx_char >= CH_LA && rx_char <= CH_LF_HEX) begin
      hex_digit = 4'(rx_char - CH_LA + 8'd10);
    end else if (rx_char >= CH_UA && rx_char <= CH_UF) begin
      hex_digit = 4'(rx_char - CH_UA + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    logic [SUM_W-1:0] sum;
    logic [23:0]      inc;
    logic [2:0]       k;
    sum = '0;
    inc = '0;
    k   = '0;
    for (int t = 0; t < LANES; t++) begin
      lane_next[t]     = lane[t];
      lane_sat_next[t] = lane_sat[t];
      if (ctrl.clear_field) begin
        lane_next[t]     = '0;
        lane_sat_next[t] = 1'b0;
      end else if (int_step || (frac_step && (3'(t) > fc))) begin
        if (int_step) begin
          inc = {20'd0, digit} * {4'd0, pow10(3'(t))};
          sum = {1'b0, lane[t], 3'b000} + {3'b000, lane[t], 1'b0} + {28'd0, inc};
        end else begin
          k   = 3'(t) - fc - 3'd1;
          inc = {20'd0, digit} * {4'd0, pow10(k)};
          sum = {4'd0, lane[t]} + {28'd0, inc};
        end
        if (sum > {4'd0, MAG_LIMIT}) begin
          lane_next[t]     = MAG_LIMIT;
          lane_sat_next[t] = 1'b1;
        end else begin
          lane_next[t] = sum[MAG_W-1:0];
        end
      end
    end
  end

  always_comb begin
    logic [SUM_W-1:0] msum;
    mag_next      = mag;
    overflow_next = overflow;
    negative_next = negative;
    point_next    = point;
    fc_next       = fc;
    started_next  = started;
    first_next    = first;
    begun_next    = begun;
    done_next     = done;
    star_next     = star;
    hex_any_next  = hex_any;
    hex_done_next = hex_done;
    hex_next      = hex;
    msum = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0} + {48'd0, digit};
    if (ctrl.clear_field) begin
      mag_next      = '0;
      overflow_next = 1'b0;
      negative_next = 1'b0;
      point_next    = 1'b0;
      fc_next       = '0;
      started_next  = 1'b0;
      first_next    = '0;
      begun_next    = 1'b0;
      done_next     = 1'b0;
      star_next     = 1'b0;
      hex_any_next  = 1'b0;
      hex_done_next = 1'b0;
      hex_next      = '0;
    end else if (ctrl.feed) begin
      if (!started) begin
        started_next = 1'b1;
        first_next   = rx_char;
      end
      if (int_step || frac_step) begin
        if (msum > {4'd0, MAG_LIMIT}) begin
          mag_next      = MAG_LIMIT;
          overflow_next = 1'b1;
        end else begin
          mag_next = msum[MAG_W-1:0];
        end
      end
      if (frac_step) begin
        fc_next = fc + 1'b1;
      end
      if (!done) begin
        if (is_digit) begin
          begun_next = 1'b1;
        end else if (rx_char == CH_DOT && !point) begin
          point_next = 1'b1;
          begun_next = 1'b1;
        end else if (!begun && is_ws) begin
          begun_next = 1'b0;
        end else if (!begun && (rx_char == CH_PLUS || rx_char == CH_MINUS)) begin
          negative_next = (rx_char == CH_MINUS);
          begun_next    = 1'b1;
        end else begin
          done_next = 1'b1;
        end
      end
      if (!star) begin
        star_next = (rx_char == CH_STAR);
      end else if (!hex_done) begin
        if (hex_ok) begin
          hex_next     = {hex[3:0], hex_digit};
          hex_any_next = 1'b1;
        end else begin
          hex_done_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < LANES; t++) begin
        lane[t] <= '0;
      end
      lane_sat <= '0;
      mag      <= '0;
      overflow <= 1'b0;
      negative <= 1'b0;
      point    <= 1'b0;
      fc       <= '0;
      started  <= 1'b0;
      first    <= '0;
      begun    <= 1'b0;
      done     <= 1'b0;
      star     <= 1'b0;
      hex_any  <= 1'b0;
      hex_done <= 1'b0;
      hex      <= '0;
    end else begin
      for (int t = 0; t < LANES; t++) begin
        lane[t] <= lane_next[t];
      end
      lane_sat <= lane_sat_next;
      mag      <= mag_next;
      overflow <= overflow_next;
      negative <= negative_next;
      point    <= point_next;
      fc       <= fc_next;
      started  <= started_next;
      first    <= first_next;
      begun    <= begun_next;
      done     <= done_next;
      star     <= star_next;
      hex_any  <= hex_any_next;
      hex_done <= hex_done_next;
      hex      <= hex_next;
    end
  end

  always_comb begin
    view.lane     = lane[frac_set];
    view.lane_sat = lane_sat[frac_set];
    view.overflow = overflow;
    view.negative = negative;
    view.fc       = fc;
    view.started  = started;
    view.first    = first;
    view.star     = star;
    view.hex_any  = hex_any;
    view.hex      = hex;
  end

endmodule
`default_nettype wire

// ===== sv/nse_fmt.sv =====
`timescale 1ns / 1ps
`default_nettype none
module nse_fmt (
  input  wire nse_pkg::field_view_t          view,
  input  wire logic [nse_pkg::FC_W-1:0]      frac_set,
  input  wire nse_pkg::kind_t                kind,
  input  wire logic [nse_pkg::FPOS_W-1:0]    fpos,
  input  wire logic                          last,
  output nse_pkg::result_t                   res
);
  import nse_pkg::*;

  logic [MAG_W-1:0] mag;
  logic             sat;

  // A saturated magnitude with more fractional digits than kept is divided
  // down from the limit, else kept at it; otherwise the matching lane is taken.
  always_comb begin
    if (view.overflow) begin
      sat = 1'b1;
      if (view.fc > frac_set) begin
        mag = cap_div(view.fc - frac_set);
      end else begin
        mag = MAG_LIMIT;
      end
    end else begin
      sat = view.lane_sat;
      mag = view.lane;
    end
  end

  always_comb begin
    res.kind   = kind;
    res.fpos   = fpos;
    res.last   = last;
    res.sat    = sat;
    res.first  = view.started ? view.first : 8'd0;
    res.has_ck = view.star && view.hex_any;
    res.ck     = (view.star && view.hex_any) ? view.hex : 8'd0;
    if (view.negative) begin
      res.value = '0 - mag;
    end else if (mag > MAG_LIMIT - 1'b1) begin
      res.value = MAG_LIMIT - 1'b1;
      res.sat   = 1'b1;
    end else begin
      res.value = mag;
    end
  end

endmodule
`default_nettype wire

// ===== sv/nmea_sentence_field_extractor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake             Payload
// stream in input      s_tvalid / s_tready   s_tdata: rx_byte
// stream out output    m_tvalid / m_tready   m_tdata, m_tuser, m_tlast: one field result
// config    input      cfg_we                cfg_wdata: frac_digits
//
// One byte is taken every cycle unless the output stalls; an accepted byte passes the input
// register, the per-byte update and then the result register before its result is valid.
// Reset is synchronous and clears the line, field and handshake state; frac_digits goes to 4.
// While m_tready is low a pending result holds, and one more byte is buffered in the
// input register before s_tready drops.
module nmea_sentence_field_extractor (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_wdata,   // frac_digits
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,     // rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [4:0] field_number, [52:5] field_value, [60:53] first_char, [68:61] checksum, [71:69] zero
  output logic [71:0]      m_tdata,
  // [2:0] sentence_kind, [3] value_saturated, [4] has_checksum
  output logic [4:0]       m_tuser,
  output logic             m_tlast      // last_field
);
  import nse_pkg::*;

  logic [FC_W-1:0]   frac_digits;
  logic [FC_W-1:0]   frac_set;
  logic              in_valid;
  logic [7:0]        in_byte;
  logic              advance;
  logic              proc;
  line_ctrl_t        ctrl;
  kind_t             kind;
  logic [FPOS_W-1:0] fpos;
  field_view_t       view;
  result_t           res_next;
  result_t           res;

  assign frac_set = (frac_digits > FC_W'(FRAC_MAX)) ? FC_W'(FRAC_MAX) : frac_digits;
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign proc     = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      frac_digits <= 3'd4;
    end else if (cfg_we) begin
      frac_digits <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      in_byte <= s_tdata;
    end
  end

  nse_line u_line (
    .clk     (clk),
    .rst     (rst),
    .proc    (proc),
    .rx_char (in_byte),
    .ctrl    (ctrl),
    .kind    (kind),
    .fpos    (fpos)
  );

  nse_field u_field (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .rx_char  (in_byte),
    .frac_set (frac_set),
    .view     (view)
  );

  nse_fmt u_fmt (
    .view     (view),
    .frac_set (frac_set),
    .kind     (kind),
    .fpos     (fpos),
    .last     (ctrl.last),
    .res      (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= proc && ctrl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && proc && ctrl.emit) begin
      res <= res_next;
    end
  end

  assign m_tdata = {3'b000, res.ck, res.first, res.value, res.fpos};
  assign m_tuser = {res.has_ck, res.sat, res.kind};
  assign m_tlast = res.last;

endmodule
`default_nettype wire

// ===== sv/nse_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module nse_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [71:0] m_tdata,
  input wire logic [4:0]  m_tuser,
  input wire logic        m_tlast
);

  `NSE_ASSERT_ALWAYS(a_reset_clears_out, clk, rst |=> !m_tvalid, "Output valid after reset.")
  `NSE_ASSERT(a_stall_holds, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "Stalled transaction changed.")
  `NSE_ASSERT(a_field_nonzero, clk, rst, m_tvalid |-> m_tdata[4:0] != 5'd0, "Field number zero emitted.")
  `NSE_ASSERT(a_top_field_last, clk, rst, m_tvalid && m_tdata[4:0] == 5'd31 |-> m_tlast, "Top field not marked last.")
  `NSE_ASSERT(a_no_ck_zero, clk, rst, m_tvalid && !m_tuser[4] |-> m_tdata[68:61] == 8'd0, "Checksum set without flag.")

endmodule

bind nmea_sentence_field_extractor nse_checker u_nse_checker (.*);
`default_nettype wire
